// ===== rtl/ptcg_pkg.sv =====
// ptcg_pkg: shared constants, types and the 5x7 font for the pov text column generator
// no dependencies; used by every other file of the block
`default_nettype none

package ptcg_pkg;

  // message store geometry
  localparam int MsgDepth = 64;
  localparam int AddrW    = (MsgDepth > 1) ? $clog2(MsgDepth) : 1;

  // field widths
  localparam int IdxW  = 6;
  localparam int CodeW = 8;
  localparam int HdgW  = 16;
  localparam int LenW  = 7;
  localparam int ColW  = 9;
  localparam int LedW  = 8;
  localparam int SlotW = 3;
  localparam int ProdW = ColW + LenW;

  // rotation and font geometry
  localparam int ColsPerRev   = 360;
  localparam int GlyphW       = 5;
  localparam int CellW        = GlyphW + 1;
  localparam int SlotSpan     = ColsPerRev / CellW;
  localparam int LedRowOffset = 1;

  // exact floor(p / 360) for p < 2**16: (p * RecipMul) >> RecipShift
  localparam int RecipShift = 24;
  localparam int RecipMul   = ((1 << RecipShift) + ColsPerRev - 1) / ColsPerRev;

  // apb
  localparam int PAddrW = 3;
  localparam int PDataW = 32;

  localparam logic [CodeW-1:0] CharSpace = 8'h20;
  localparam logic [CodeW-1:0] CharZero  = 8'h30;
  localparam logic [CodeW-1:0] CharNine  = 8'h39;
  localparam logic [CodeW-1:0] CharUpA   = 8'h41;
  localparam logic [CodeW-1:0] CharUpZ   = 8'h5A;
  localparam logic [CodeW-1:0] CharLoA   = 8'h61;
  localparam logic [CodeW-1:0] CharLoZ   = 8'h7A;
  localparam logic [CodeW-1:0] CaseFold  = 8'h20;

  typedef enum logic {
    KindChar    = 1'b0,
    KindHeading = 1'b1
  } kind_e;

  typedef enum logic {
    ModeWait = 1'b0,
    ModeText = 1'b1
  } mode_e;

  typedef enum logic [PAddrW-3:0] {
    RegMsgLen = 1'b0
  } reg_e;

  // message store access, one write and one read port
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [CodeW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // glyph columns, first column in the top byte
  localparam logic [39:0] DigitFont [10] = '{
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E
  };

  localparam logic [39:0] LetterFont [26] = '{
    40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C,
    40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F,
    40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06,
    40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01,
    40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  // seven font rows of one glyph column, blank for the spacing slot and other codes
  function automatic logic [6:0] glyph_col(logic [CodeW-1:0] code, logic [SlotW-1:0] slot);
    logic [CodeW-1:0] c;
    logic [39:0]      row;
    logic [6:0]       bits;
    c    = code;
    row  = '0;
    bits = '0;
    if (c >= CharLoA && c <= CharLoZ) begin
      c = c - CaseFold;
    end
    if (c >= CharZero && c <= CharNine) begin
      row = DigitFont[4'(c - CharZero)];
    end else if (c >= CharUpA && c <= CharUpZ) begin
      row = LetterFont[5'(c - CharUpA)];
    end
    if (int'(slot) < GlyphW) begin
      bits = row[(GlyphW - 1 - int'(slot)) * 8 +: 7];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ptcg_if.sv =====
// ptcg_in_if / ptcg_out_if: valid/ready channels carrying input and result items
// depends on ptcg_pkg for field widths
`default_nettype none

interface ptcg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ptcg_pkg::IdxW-1:0]   char_index;
  logic [ptcg_pkg::CodeW-1:0]  char_code;
  logic                        hdg_usable;
  logic signed [ptcg_pkg::HdgW-1:0] heading_q4;

  modport source (output valid, kind, char_index, char_code, hdg_usable, heading_q4,
                  input ready);
  modport sink   (input valid, kind, char_index, char_code, hdg_usable, heading_q4,
                  output ready);
endinterface

interface ptcg_out_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [ptcg_pkg::LedW-1:0]  led_mask;
  logic [ptcg_pkg::ColW-1:0]  column_index;

  modport source (output valid, mode, led_mask, column_index, input ready);
  modport sink   (input valid, mode, led_mask, column_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptcg_cfg_regs.sv =====
// ptcg_cfg_regs: apb register file holding the message length
// depends on ptcg_pkg
`default_nettype none

module ptcg_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ptcg_pkg::PAddrW-1:0]   paddr,
  input  wire logic [ptcg_pkg::PDataW-1:0]   pwdata,
  output logic      [ptcg_pkg::PDataW-1:0]   prdata,
  output logic                               pready,
  output logic      [ptcg_pkg::LenW-1:0]     len_o
);

  logic [ptcg_pkg::LenW-1:0] len_q, len_d;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr[ptcg_pkg::PAddrW-1:2] == ptcg_pkg::RegMsgLen);

  always_comb begin
    len_d = len_q;
    if (wr_en) begin
      len_d = pwdata[ptcg_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= ptcg_pkg::LenW'(1);
    end else begin
      len_q <= len_d;
    end
  end

  always_comb begin
    unique case (paddr[ptcg_pkg::PAddrW-1:2])
      ptcg_pkg::RegMsgLen: prdata = ptcg_pkg::PDataW'(len_q);
      default:             prdata = '0;
    endcase
  end

  // zero acts as one, anything past the store depth as the depth
  always_comb begin
    if (len_q == '0) begin
      len_o = ptcg_pkg::LenW'(1);
    end else if (int'(len_q) > ptcg_pkg::MsgDepth) begin
      len_o = ptcg_pkg::LenW'(ptcg_pkg::MsgDepth);
    end else begin
      len_o = len_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptcg_msg_ram.sv =====
// ptcg_msg_ram: message store, synchronous ram with registered read and per-entry valid bits
// depends on ptcg_pkg (ram_req_t, depth); unwritten entries read as space
`default_nettype none

module ptcg_msg_ram (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ptcg_pkg::ram_req_t           req_i,
  output logic      [ptcg_pkg::CodeW-1:0]   rdata_o
);

  logic [ptcg_pkg::CodeW-1:0]    mem [ptcg_pkg::MsgDepth];
  logic [ptcg_pkg::MsgDepth-1:0] vld_q;
  logic [ptcg_pkg::CodeW-1:0]    rd_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : ptcg_pkg::CharSpace;

endmodule

`default_nettype wire

// ===== rtl/pov_text_column_generator_core.sv =====
// pov_text_column_generator_core: top level, heading to text column pipeline around the store
// depends on ptcg_pkg, ptcg_if, ptcg_cfg_regs, ptcg_msg_ram
//
// channel  | dir | handshake     | payload
// ---------+-----+---------------+---------------------------------------------------
// in_ch    | in  | valid/ready   | kind, char_index, char_code, hdg_usable, heading_q4
// out_ch   | out | valid/ready   | mode, led_mask, column_index
// apb      | in  | psel/penable  | paddr, pwdata, prdata (message_length at 0x0)
//
// one item per cycle sustained while the output does not stall; a result passes the
// stage 1, stage 2 and stage 3 registers into the output register, from which it can leave
// (column select at acceptance, then reciprocal multiply, store read, glyph lookup)
// the store sees all reads and writes in one stage, so items hit it in arrival order
// reset takes effect at once: valid bits make the whole store read as spaces
// a stalled output only blocks the pipe once every stage ahead of it is full;
// writes and repeated columns leave the pipe before the output register
`default_nettype none

module pov_text_column_generator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  ptcg_in_if.sink                          in_ch,
  ptcg_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ptcg_pkg::PAddrW-1:0] paddr,
  input  wire logic [ptcg_pkg::PDataW-1:0] pwdata,
  output logic      [ptcg_pkg::PDataW-1:0] prdata,
  output logic                             pready
);

  // ---------------------------------------------------------------- config
  logic [ptcg_pkg::LenW-1:0] len_eff;

  ptcg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .len_o   (len_eff)
  );

  // ---------------------------------------------------------------- handshake / stalls
  logic in_fire;
  logic s1_free, s2_free, s3_free, o_free;
  logic m1, m2, m3;

  // stage regs
  logic                          v1_q, v2_q, v3_q, ov_q;
  logic                          e1_q, e2_q;
  logic                          k1_q, k2_q;
  logic                          mode1_q, mode2_q, mode3_q;
  logic [ptcg_pkg::ColW-1:0]     col1_q, col2_q, col3_q;
  logic [ptcg_pkg::ProdW-1:0]    p1_q, p2_q;
  logic [ptcg_pkg::LenW-1:0]     ci2_q;
  logic [ptcg_pkg::IdxW-1:0]     idx1_q, idx2_q;
  logic [ptcg_pkg::CodeW-1:0]    code1_q, code2_q;
  logic [ptcg_pkg::SlotW-1:0]    slot3_q;

  // output regs
  logic                          omode_q;
  logic [ptcg_pkg::LedW-1:0]     oled_q;
  logic [ptcg_pkg::ColW-1:0]     ocol_q;

  // a stage moves when the one ahead is free; non-emitting items drop out after the store
  assign o_free  = !ov_q || out_ch.ready;
  assign s3_free = !v3_q || o_free;
  assign m3      = v3_q && o_free;
  assign m2      = v2_q && (s3_free || !e2_q);
  assign s2_free = !v2_q || m2;
  assign m1      = v1_q && s2_free;
  assign s1_free = !v1_q || m1;

  assign in_ch.ready = s1_free;
  assign in_fire     = in_ch.valid && s1_free;

  // ---------------------------------------------------------------- stage 0: column select
  logic [10:0]                raw_col;
  logic [ptcg_pkg::ColW-1:0]  col_s0;
  logic                       dup_s0;
  logic                       is_hdg;
  logic                       emit_s0;
  logic [ptcg_pkg::ProdW-1:0] p_s0;
  logic [ptcg_pkg::ColW-1:0]  last_q, last_d;
  logic                       known_q, known_d;

  assign raw_col = in_ch.heading_q4[ptcg_pkg::HdgW-2:4];
  assign is_hdg  = (in_ch.kind == ptcg_pkg::KindHeading);

  // truncate toward zero: negative headings all land on column zero, columns past 359 clamp to 359
  always_comb begin
    if (in_ch.heading_q4[ptcg_pkg::HdgW-1]) begin
      col_s0 = '0;
    end else if (raw_col > 11'(ptcg_pkg::ColsPerRev - 1)) begin
      col_s0 = ptcg_pkg::ColW'(ptcg_pkg::ColsPerRev - 1);
    end else begin
      col_s0 = raw_col[ptcg_pkg::ColW-1:0];
    end
  end

  assign dup_s0  = known_q && (col_s0 == last_q);
  assign emit_s0 = is_hdg && (!in_ch.hdg_usable || !dup_s0);
  // message column numerator: col * len, later split by 360 into char and slot
  assign p_s0    = ptcg_pkg::ProdW'(col_s0) * ptcg_pkg::ProdW'(len_eff);

  always_comb begin
    last_d  = last_q;
    known_d = known_q;
    if (in_fire && is_hdg) begin
      if (!in_ch.hdg_usable) begin
        known_d = 1'b0;
      end else if (!dup_s0) begin
        last_d  = col_s0;
        known_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      known_q <= 1'b0;
    end else begin
      last_q  <= last_d;
      known_q <= known_d;
    end
  end

  // ---------------------------------------------------------------- stage 1 regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_free) begin
      v1_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e1_q    <= emit_s0;
      k1_q    <= is_hdg;
      mode1_q <= in_ch.hdg_usable;
      col1_q  <= in_ch.hdg_usable ? col_s0 : '0;
      p1_q    <= p_s0;
      idx1_q  <= in_ch.char_index;
      code1_q <= in_ch.char_code;
    end
  end

  // ---------------------------------------------------------------- stage 1: char index
  logic [31:0] recip_prod;

  // floor(p / 360) by reciprocal, exact over the whole product range
  assign recip_prod = 32'(p1_q) * 32'(ptcg_pkg::RecipMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s2_free) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m1) begin
      e2_q    <= e1_q;
      k2_q    <= k1_q;
      mode2_q <= mode1_q;
      col2_q  <= col1_q;
      p2_q    <= p1_q;
      ci2_q   <= recip_prod[ptcg_pkg::RecipShift +: ptcg_pkg::LenW];
      idx2_q  <= idx1_q;
      code2_q <= code1_q;
    end
  end

  // ---------------------------------------------------------------- stage 2: slot, store access
  logic [ptcg_pkg::ProdW-1:0] rem_full;
  logic [ptcg_pkg::ColW-1:0]  rem;
  logic [ptcg_pkg::SlotW-1:0] slot_s2;
  ptcg_pkg::ram_req_t         ram_req;
  logic [ptcg_pkg::CodeW-1:0] ram_rdata;

  assign rem_full = p2_q - ptcg_pkg::ProdW'(ci2_q) * ptcg_pkg::ProdW'(ptcg_pkg::ColsPerRev);
  assign rem      = rem_full[ptcg_pkg::ColW-1:0];

  // remainder below 360 picks one of six slots of 60 each
  always_comb begin
    slot_s2 = ptcg_pkg::SlotW'(ptcg_pkg::CellW - 1);
    for (int i = ptcg_pkg::CellW - 1; i > 0; i--) begin
      if (rem < ptcg_pkg::ColW'(i * ptcg_pkg::SlotSpan)) begin
        slot_s2 = ptcg_pkg::SlotW'(i - 1);
      end
    end
  end

  always_comb begin
    ram_req.we    = m2 && !k2_q && (int'(idx2_q) < ptcg_pkg::MsgDepth);
    ram_req.waddr = ptcg_pkg::AddrW'(idx2_q);
    ram_req.wdata = code2_q;
    ram_req.re    = m2 && e2_q && mode2_q;
    ram_req.raddr = ptcg_pkg::AddrW'(ci2_q);
  end

  ptcg_msg_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 3 regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (s3_free) begin
      v3_q <= m2 && e2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m2 && e2_q) begin
      mode3_q <= mode2_q;
      col3_q  <= col2_q;
      slot3_q <= slot_s2;
    end
  end

  // ---------------------------------------------------------------- stage 3: glyph, output reg
  logic [6:0]                glyph_bits;
  logic [ptcg_pkg::LedW-1:0] led_s3;

  assign glyph_bits = ptcg_pkg::glyph_col(ram_rdata, slot3_q);
  // font row r drives led r+1, led 0 stays dark
  assign led_s3     = mode3_q ? (ptcg_pkg::LedW'({1'b0, glyph_bits}) << ptcg_pkg::LedRowOffset)
                              : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (o_free) begin
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m3) begin
      omode_q <= mode3_q;
      oled_q  <= led_s3;
      ocol_q  <= col3_q;
    end
  end

  assign out_ch.valid        = ov_q;
  assign out_ch.mode         = omode_q;
  assign out_ch.led_mask     = oled_q;
  assign out_ch.column_index = ocol_q;

  // ---------------------------------------------------------------- assertions
  // waiting indicator carries no column and no lit foreground
  a_wait_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.mode == ptcg_pkg::ModeWait) |->
      (out_ch.led_mask == '0) && (out_ch.column_index == '0))
    else $error("waiting item with nonzero payload");

  // text columns stay in range and never light the bottom led
  a_text_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.mode == ptcg_pkg::ModeText) |->
      (out_ch.led_mask[0] == 1'b0) &&
      (out_ch.column_index <= ptcg_pkg::ColW'(ptcg_pkg::ColsPerRev - 1)))
    else $error("text item out of range");

  // an invalid heading forgets the last column
  a_forget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_hdg && !in_ch.hdg_usable |=> !known_q)
    else $error("last column still known after invalid heading");

  // a store read only happens for a text item heading into a free stage
  a_read_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.re |-> v2_q && s3_free && !ram_req.we)
    else $error("store read without a text item");

endmodule

`default_nettype wire
